// ----- rtl/core/ism_pkg.sv -----
// ----------------------------------------------------------------------------
// ism_pkg
// Shared types, codes and defaults for the interval set merge/lookup block.
// ----------------------------------------------------------------------------
package ism_pkg;

    // default sizes
    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_LEFT  = 2'd0;
    localparam logic [1:0] CFG_RIGHT = 2'd1;

    // datapath operations
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_SCAN_P = 3'd2;
    localparam logic [2:0] OP_SCAN_J = 3'd3;
    localparam logic [2:0] OP_SCAN_I = 3'd4;
    localparam logic [2:0] OP_COPY   = 3'd5;
    localparam logic [2:0] OP_FIND   = 3'd6;

    typedef struct packed {
        logic        command;
        logic [31:0] interval_start;
        logic [31:0] interval_end;
        logic [31:0] query_point;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_start;
        logic [31:0] result_end;
    } t_out_word;

    typedef struct packed {
        logic [2:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic cont;
    } t_dp_stat;

endpackage

// ----- rtl/core/ism_ctrl.sv -----
// ----------------------------------------------------------------------------
// ism_ctrl
// Sequencer: walks the scan, merge and copy phases of an insert, or the find scan, and issues datapath ops.
// ----------------------------------------------------------------------------
module ism_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_command,
    input  ism_pkg::t_dp_stat i_stat,
    output ism_pkg::t_dp_cmd  o_cmd,
    output logic              busy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_P    = 3'd1;
    localparam logic [2:0] S_J    = 3'd2;
    localparam logic [2:0] S_I    = 3'd3;
    localparam logic [2:0] S_C    = 3'd4;
    localparam logic [2:0] S_F    = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state and op decode
    always_comb begin
        n_state  = r_state;
        o_cmd.op = ism_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = ism_pkg::OP_LOAD;
                    n_state  = (i_command == ism_pkg::CMD_FIND) ? S_F : S_P;
                end
            end
            S_P: begin
                o_cmd.op = ism_pkg::OP_SCAN_P;
                if (!i_stat.cont) n_state = S_J;
            end
            S_J: begin
                o_cmd.op = ism_pkg::OP_SCAN_J;
                if (!i_stat.cont) n_state = S_I;
            end
            S_I: begin
                o_cmd.op = ism_pkg::OP_SCAN_I;
                if (!i_stat.cont) n_state = S_C;
            end
            S_C: begin
                o_cmd.op = ism_pkg::OP_COPY;
                if (!i_stat.cont) n_state = S_IDLE;
            end
            S_F: begin
                o_cmd.op = ism_pkg::OP_FIND;
                if (!i_stat.cont) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ----- rtl/core/ism_dp.sv -----
// ----------------------------------------------------------------------------
// ism_dp
// Datapath: ping-pong interval table, scan indexes, union and result register.
// ----------------------------------------------------------------------------
module ism_dp #(
    parameter int CAPACITY    = ism_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = ism_pkg::VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ism_pkg::t_dp_cmd   i_cmd,
    input  ism_pkg::t_in_word  i_in,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic               i_cfg_data,
    output ism_pkg::t_dp_stat  o_stat,
    output ism_pkg::t_out_word o_result,
    output logic               o_result_strobe
);

    localparam int D     = VALUE_WIDTH;
    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int WW    = $clog2(CAPACITY + 2);
    localparam int DEPTH = 2 * (1 << AW);

    function automatic logic precedes(input logic [D-1:0] x, input logic [D-1:0] y,
                                      input logic incl);
        return incl ? (x <= y) : (x < y);
    endfunction

    // table banks, bank bit on top
    logic [D-1:0] mem_s [DEPTH];
    logic [D-1:0] mem_e [DEPTH];
    logic [D-1:0] r_rd_s, r_rd_e;

    logic [D-1:0] r_a, r_b, r_x, r_hs, r_he;
    logic [D-1:0] n_a, n_b, n_x, n_hs, n_he;
    logic [CW-1:0] r_k, r_p, r_i, r_j, r_cnt;
    logic [CW-1:0] n_k, n_p, n_i, n_j, n_cnt, n_idx;
    logic [WW-1:0] r_w, n_w, w_fin;
    logic r_ins, r_dup, r_have, r_bank, r_left, r_right, r_strobe;
    logic n_ins, n_dup, n_have, n_bank, n_strobe;
    ism_pkg::t_out_word r_out, n_out;

    logic          we;
    logic [D-1:0]  w_s, w_e;
    logic          touch, k_in, skip, lt, eq, full;

    assign touch = r_left | r_right;
    assign k_in  = (r_k < r_cnt);
    assign skip  = (r_k >= r_i) && (r_k < r_j);
    assign lt    = (r_rd_s < r_a) || ((r_rd_s == r_a) && (r_rd_e < r_b));
    assign eq    = (r_rd_s == r_a) && (r_rd_e == r_b);
    assign w_fin = r_w + WW'(!r_ins);
    assign full  = !r_dup && (w_fin > WW'(CAPACITY));

    // per-op register updates
    always_comb begin
        n_a = r_a; n_b = r_b; n_x = r_x; n_hs = r_hs; n_he = r_he;
        n_k = r_k; n_p = r_p; n_i = r_i; n_j = r_j; n_cnt = r_cnt; n_w = r_w;
        n_ins = r_ins; n_dup = r_dup; n_have = r_have; n_bank = r_bank;
        n_out = r_out; n_strobe = 1'b0;
        n_idx = r_k;
        we = 1'b0; w_s = r_rd_s; w_e = r_rd_e;
        o_stat.cont = 1'b0;
        case (i_cmd.op)
            ism_pkg::OP_LOAD: begin
                n_a    = D'(i_in.interval_start);
                n_b    = D'(i_in.interval_end);
                n_x    = D'(i_in.query_point);
                n_k    = '0;
                n_have = 1'b0;
                n_idx  = '0;
            end
            // find first stored start above the new start
            ism_pkg::OP_SCAN_P: begin
                o_stat.cont = k_in && (r_rd_s <= r_a);
                if (o_stat.cont) begin
                    n_k   = r_k + 1'b1;
                    n_idx = r_k + 1'b1;
                end else begin
                    n_p = r_k;
                end
            end
            // absorb following entries into the end
            ism_pkg::OP_SCAN_J: begin
                o_stat.cont = k_in && precedes(r_rd_s, r_b, touch);
                if (o_stat.cont) begin
                    if (r_rd_e > r_b) n_b = r_rd_e;
                    n_k   = r_k + 1'b1;
                    n_idx = r_k + 1'b1;
                end else begin
                    n_j   = r_k;
                    n_i   = r_p;
                    n_idx = r_p - 1'b1;
                end
            end
            // walk back absorbing earlier entries
            ism_pkg::OP_SCAN_I: begin
                o_stat.cont = (r_i != '0) && precedes(r_a, r_rd_e, touch);
                if (o_stat.cont) begin
                    if (r_rd_s < r_a) n_a = r_rd_s;
                    if (r_rd_e > r_b) n_b = r_rd_e;
                    n_i   = r_i - 1'b1;
                    n_idx = r_i - CW'(2);
                end else begin
                    n_k   = '0;
                    n_w   = '0;
                    n_ins = 1'b0;
                    n_dup = 1'b0;
                    n_idx = '0;
                end
            end
            // rebuild into the other bank with the union in order
            ism_pkg::OP_COPY: begin
                o_stat.cont = k_in;
                if (k_in) begin
                    if (skip) begin
                        n_k   = r_k + 1'b1;
                        n_idx = r_k + 1'b1;
                    end else if (!r_ins && !lt && !eq) begin
                        we    = 1'b1;
                        w_s   = r_a;
                        w_e   = r_b;
                        n_w   = r_w + 1'b1;
                        n_ins = 1'b1;
                    end else begin
                        we    = 1'b1;
                        n_w   = r_w + 1'b1;
                        n_k   = r_k + 1'b1;
                        n_idx = r_k + 1'b1;
                        // kept entry equal to the union stands for it
                        if (!r_ins && eq) begin
                            n_ins = 1'b1;
                            n_dup = 1'b1;
                        end
                    end
                end else begin
                    if (!r_ins) begin
                        we  = 1'b1;
                        w_s = r_a;
                        w_e = r_b;
                    end
                    n_strobe = 1'b1;
                    if (full) begin
                        n_out = '{ism_pkg::ST_FULL, 32'd0, 32'd0};
                    end else begin
                        n_cnt  = CW'(w_fin);
                        n_bank = !r_bank;
                        n_out  = '{ism_pkg::ST_OK, 32'(r_a), 32'(r_b)};
                    end
                end
            end
            // locate last start at or below the point
            ism_pkg::OP_FIND: begin
                o_stat.cont = k_in && (r_rd_s <= r_x);
                if (o_stat.cont) begin
                    n_hs   = r_rd_s;
                    n_he   = r_rd_e;
                    n_have = 1'b1;
                    n_k    = r_k + 1'b1;
                    n_idx  = r_k + 1'b1;
                end else begin
                    n_strobe = 1'b1;
                    if (!r_have || precedes(r_he, r_x, !r_right) ||
                        precedes(r_x, r_hs, !r_left)) begin
                        n_out = '{ism_pkg::ST_NOT_FOUND, 32'd0, 32'd0};
                    end else begin
                        n_out = '{ism_pkg::ST_OK, 32'(r_hs), 32'(r_he)};
                    end
                end
            end
            default: ;
        endcase
    end

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (we && (r_w < WW'(CAPACITY))) begin
            mem_s[{!r_bank, r_w[AW-1:0]}] <= w_s;
            mem_e[{!r_bank, r_w[AW-1:0]}] <= w_e;
        end
        r_rd_s <= mem_s[{n_bank, n_idx[AW-1:0]}];
        r_rd_e <= mem_e[{n_bank, n_idx[AW-1:0]}];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_bank   <= 1'b0;
            r_strobe <= 1'b0;
            r_left   <= 1'b1;
            r_right  <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_bank   <= n_bank;
            r_strobe <= n_strobe;
            if (i_cfg_we && i_cfg_index == ism_pkg::CFG_LEFT)  r_left  <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == ism_pkg::CFG_RIGHT) r_right <= i_cfg_data;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_a <= n_a; r_b <= n_b; r_x <= n_x; r_hs <= n_hs; r_he <= n_he;
        r_k <= n_k; r_p <= n_p; r_i <= n_i; r_j <= n_j; r_w <= n_w;
        r_ins <= n_ins; r_dup <= n_dup; r_have <= n_have;
        r_out <= n_out;
    end

    assign o_result        = r_out;
    assign o_result_strobe = r_strobe;

endmodule

// ----- rtl/core/interval_set_merge_lookup.sv -----
// ----------------------------------------------------------------------------
// interval_set_merge_lookup
// Sorted disjoint interval table with merge-on-insert and point lookup.
// ----------------------------------------------------------------------------
// find: scans from the first entry past every entry with start at or below the point
// insert: forward scan, back walk, then copy into the other bank, all paced by
//   the single table read port
// one word at a time; busy falls as the result strobe rises, which cannot stall
// sync reset empties the table (count zero, no clearing pass) and sets config
module interval_set_merge_lookup #(
    parameter int CAPACITY    = ism_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = ism_pkg::VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ism_pkg::t_in_word  i_in,
    output ism_pkg::t_out_word o_result,
    output logic               o_result_strobe,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic               i_cfg_data
);

    ism_pkg::t_dp_cmd  cmd;
    ism_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    ism_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_in.command),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .busy      (busy)
    );

    ism_dp #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_in            (i_in),
        .i_cfg_we        (i_cfg_valid & o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_stat          (stat),
        .o_result        (o_result),
        .o_result_strobe (o_result_strobe)
    );

endmodule

// ----- rtl/core/ism_checker.sv -----
// ----------------------------------------------------------------------------
// ism_checker
// Port-level checks on command/result sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module ism_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input ism_pkg::t_out_word o_result,
    input logic               o_result_strobe
);

    // accepted word makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accept did not raise busy");

    // a result only ends a busy stretch
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (!busy && $past(busy))) else $error("stray result strobe");

    // one result per word
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe) else $error("repeated result strobe");

    // failed results carry zero bounds
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.status != ism_pkg::ST_OK) |->
        (o_result.result_start == 32'd0 && o_result.result_end == 32'd0 &&
         (o_result.status == ism_pkg::ST_NOT_FOUND || o_result.status == ism_pkg::ST_FULL)))
        else $error("bad failed result");

endmodule

bind interval_set_merge_lookup ism_checker u_ism_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result        (o_result),
    .o_result_strobe (o_result_strobe)
);

// ----- test/interval_set_merge_lookup_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_set_merge_lookup_checker
// Watches the command, result and register channels of the interval table,
// keeps its own copy of the table, predicts each result and compares it.
// ----------------------------------------------------------------------------
module interval_set_merge_lookup_checker #(
    parameter int CAPACITY = ism_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  ism_pkg::t_in_word  i_in,
    input  ism_pkg::t_out_word i_result,
    input  logic               i_result_strobe,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic               i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic [31:0]        tbl_starts [CAPACITY];
    logic [31:0]        tbl_ends [CAPACITY];
    int                 tbl_count;
    logic               left_incl;
    logic               right_incl;
    ism_pkg::t_out_word expected_words [$];

    assign o_pending = expected_words.size();

    function automatic bit edge_ok(logic [31:0] x, logic [31:0] y, bit incl);
        return incl ? (x <= y) : (x < y);
    endfunction

    // merge the new interval into the table and return the word it reports
    function automatic ism_pkg::t_out_word merge_insert(logic [31:0] a, logic [31:0] b);
        logic [31:0]        ns [$];
        logic [31:0]        ne [$];
        ism_pkg::t_out_word w;
        bit                 touch;
        int                 p, i, j, pos;
        touch = left_incl | right_incl;
        p = 0;
        while (p < tbl_count && tbl_starts[p] <= a) p++;
        j = p;
        while (j < tbl_count && edge_ok(tbl_starts[j], b, touch)) begin
            if (tbl_ends[j] > b) b = tbl_ends[j];
            j++;
        end
        i = p;
        while (i > 0 && edge_ok(a, tbl_ends[i-1], touch)) begin
            if (tbl_starts[i-1] < a) a = tbl_starts[i-1];
            if (tbl_ends[i-1] > b) b = tbl_ends[i-1];
            i--;
        end
        for (int k = 0; k < tbl_count; k++) begin
            if (k >= i && k < j) continue;
            ns.push_back(tbl_starts[k]);
            ne.push_back(tbl_ends[k]);
        end
        pos = 0;
        while (pos < ns.size() && (ns[pos] < a || (ns[pos] == a && ne[pos] < b))) pos++;
        w = '{status: ism_pkg::ST_OK, result_start: a, result_end: b};
        if (!(pos < ns.size() && ns[pos] == a && ne[pos] == b)) begin
            if (ns.size() + 1 > CAPACITY) begin
                return '{status: ism_pkg::ST_FULL, result_start: '0, result_end: '0};
            end
            ns.insert(pos, a);
            ne.insert(pos, b);
        end
        for (int k = 0; k < ns.size(); k++) begin
            tbl_starts[k] = ns[k];
            tbl_ends[k] = ne[k];
        end
        tbl_count = ns.size();
        return w;
    endfunction

    // find the stored interval holding the point
    function automatic ism_pkg::t_out_word point_lookup(logic [31:0] x);
        ism_pkg::t_out_word miss;
        int                 p;
        miss = '{status: ism_pkg::ST_NOT_FOUND, result_start: '0, result_end: '0};
        p = 0;
        while (p < tbl_count && tbl_starts[p] <= x) p++;
        if (p == 0) return miss;
        if (edge_ok(tbl_ends[p-1], x, !right_incl)) return miss;
        if (edge_ok(x, tbl_starts[p-1], !left_incl)) return miss;
        return '{status: ism_pkg::ST_OK, result_start: tbl_starts[p-1],
                 result_end: tbl_ends[p-1]};
    endfunction

    // watch all channels
    always @(posedge i_clk) begin
        ism_pkg::t_out_word exp_w;
        if (!i_rst_n) begin
            tbl_count = 0;
            left_incl = 1'b1;
            right_incl = 1'b0;
            o_fail_count = 0;
            expected_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == ism_pkg::CFG_LEFT) left_incl = i_cfg_data;
                else if (i_cfg_index == ism_pkg::CFG_RIGHT) right_incl = i_cfg_data;
            end
            if (i_result_strobe) begin
                if (expected_words.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result word %h", i_result);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (exp_w.status !== i_result.status ||
                        exp_w.result_start !== i_result.result_start ||
                        exp_w.result_end !== i_result.result_end) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected st=%0d %h..%h got st=%0d %h..%h",
                                     exp_w.status, exp_w.result_start, exp_w.result_end,
                                     i_result.status, i_result.result_start,
                                     i_result.result_end);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (i_in.command == ism_pkg::CMD_INSERT)
                    expected_words.push_back(merge_insert(i_in.interval_start,
                                                          i_in.interval_end));
                else
                    expected_words.push_back(point_lookup(i_in.query_point));
            end
        end
    end

endmodule

// ----- test/interval_set_merge_lookup_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_set_merge_lookup_test
// Drives inserts and finds in bursts through every edge-inclusion setting,
// with directed corner cases first; the checker predicts and compares.
// ----------------------------------------------------------------------------
module interval_set_merge_lookup_test;

    localparam int CAP = ism_pkg::CAPACITY_DEF;
    localparam int LIMIT = 3000000;
    // index with no register behind it
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    ism_pkg::t_in_word  in_word;
    ism_pkg::t_out_word result_word;
    logic               result_strobe;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic               cfg_data;
    int                 fail_count;
    int                 pending;
    int                 cycle_count;

    interval_set_merge_lookup uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_in(in_word), .o_result(result_word), .o_result_strobe(result_strobe),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    interval_set_merge_lookup_checker #(.CAPACITY(CAP)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_in(in_word), .i_result(result_word), .i_result_strobe(result_strobe),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > LIMIT) begin
                $display("interval_set_merge_lookup verification failed");
                $finish;
            end
        end
    end

    // send one word and hold it until the block is no longer busy
    task automatic send_word(bit cmd, logic [31:0] a, logic [31:0] b, logic [31:0] q);
        start <= 1'b1;
        in_word <= '{command: cmd, interval_start: a, interval_end: b, query_point: q};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, bit val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // drain results, then let the block settle before a register write
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (3 * CAP + 10) @(posedge i_clk);
    endtask

    // mostly small values so intervals meet; sometimes full range
    function automatic logic [31:0] rand_value(int span);
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'hFFFF_FFFF - $urandom_range(0, span);
            default: return $urandom_range(0, span);
        endcase
    endfunction

    task automatic random_phase(int count, int span);
        int          sent;
        int          burst;
        logic [31:0] a;
        logic [31:0] len;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 20);
            repeat (burst) begin
                a = rand_value(span);
                len = $urandom_range(0, 6);
                if ($urandom_range(0, 15) == 0) len = $urandom();
                if ($urandom_range(0, 1))
                    send_word(ism_pkg::CMD_INSERT, a, a + len, $urandom());
                else if ($urandom_range(0, 19) == 0)
                    send_word(ism_pkg::CMD_INSERT, a + len, a, $urandom());
                else
                    send_word(ism_pkg::CMD_FIND, $urandom(), $urandom(), rand_value(span));
                sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
        end
    endtask

    initial begin
        int phase;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        in_word <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= ism_pkg::CFG_LEFT;
        cfg_data <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, touching edges, duplicate, reversed, misses
        send_word(ism_pkg::CMD_FIND, 0, 0, 32'd5);
        send_word(ism_pkg::CMD_INSERT, 32'd10, 32'd20, 0);
        send_word(ism_pkg::CMD_INSERT, 32'd20, 32'd30, 0);
        send_word(ism_pkg::CMD_INSERT, 32'd10, 32'd30, 0);
        send_word(ism_pkg::CMD_INSERT, 32'd40, 32'd35, 0);
        send_word(ism_pkg::CMD_INSERT, 0, 0, 0);
        send_word(ism_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_word(ism_pkg::CMD_INSERT, 32'h8000_0000, 32'hFFFF_FFFE, 0);
        send_word(ism_pkg::CMD_FIND, 0, 0, 32'd10);
        send_word(ism_pkg::CMD_FIND, 0, 0, 32'd30);
        send_word(ism_pkg::CMD_FIND, 0, 0, 32'hFFFF_FFFF);
        send_word(ism_pkg::CMD_FIND, 0, 0, 0);
        send_word(ism_pkg::CMD_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd33);
        send_word(ism_pkg::CMD_INSERT, 32'd5, 32'd50, 32'hFFFF_FFFF);
        // fill past capacity with spaced points to reach table full
        for (int k = 0; k < CAP + 3; k++)
            send_word(ism_pkg::CMD_INSERT, 32'd1000 + 4 * k, 32'd1001 + 4 * k, 0);
        send_word(ism_pkg::CMD_INSERT, 32'd1000, 32'd1001, 0);
        send_word(ism_pkg::CMD_FIND, 0, 0, 32'd1004);
        drain();
        write_reg(ism_pkg::CFG_LEFT, 1'b0);
        write_reg(ism_pkg::CFG_RIGHT, 1'b0);
        send_word(ism_pkg::CMD_FIND, 0, 0, 32'd1004);
        send_word(ism_pkg::CMD_FIND, 0, 0, 32'd1005);
        send_word(ism_pkg::CMD_INSERT, 32'd1001, 32'd1004, 0);
        drain();

        // random phases over every register setting
        for (phase = 0; phase < 8; phase++) begin
            write_reg(ism_pkg::CFG_LEFT, phase[0]);
            write_reg(ism_pkg::CFG_RIGHT, phase[1]);
            if (phase == 4) write_reg(CFG_SPARE, 1'b1);
            random_phase(200, (phase % 2) ? 400 : 60);
            drain();
        end

        if (fail_count == 0) begin
            $display("interval_set_merge_lookup verification clean");
        end else begin
            $display("interval_set_merge_lookup verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ism_pkg.sv
rtl/core/ism_ctrl.sv
rtl/core/ism_dp.sv
rtl/core/interval_set_merge_lookup.sv
rtl/core/ism_checker.sv
test/interval_set_merge_lookup_checker.sv
test/interval_set_merge_lookup_test.sv
